/* design/dis_pkg.sv */
// shared types and defaults for the depth insertion sorter
package dis_pkg;

   localparam int MAX_ITEMS_DEFAULT = 16;
   localparam int KEY_BITS_DEFAULT  = 32;
   localparam int ID_BITS_DEFAULT   = 8;

   // sorter phase: loading items or draining the sorted run
   typedef enum logic {
      ST_LOAD,
      ST_DRAIN
   } dis_state_type;

   // per-cycle command broadcast to every cell of the chain
   typedef struct packed {
      logic insert;   // place the broadcast item, shifting larger keys up
      logic drain;    // every cell takes its upper neighbor's contents
   } dis_ctrl_type;

endpackage

/* design/dis_cell.sv */
// one compare-and-shift cell of the insertion chain
module dis_cell #(
   parameter int KEY_BITS = dis_pkg::KEY_BITS_DEFAULT,
   parameter int ID_BITS  = dis_pkg::ID_BITS_DEFAULT
) (
   input  logic                 clock,
   input  dis_pkg::dis_ctrl_type ctrl,
   input  logic                 occupied,
   input  logic [KEY_BITS-1:0]  new_key,
   input  logic [ID_BITS-1:0]   new_id,
   input  logic                 prev_greater,
   input  logic [KEY_BITS-1:0]  prev_key,
   input  logic [ID_BITS-1:0]   prev_id,
   input  logic [KEY_BITS-1:0]  next_key,
   input  logic [ID_BITS-1:0]   next_id,
   output logic                 greater,
   output logic [KEY_BITS-1:0]  key,
   output logic [ID_BITS-1:0]   id
);

   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [ID_BITS-1:0]  id_ff, id_in;

   // strictly greater keeps equal keys ahead of the new item
   assign greater = occupied && ($signed(key_ff) > $signed(new_key));

   always_comb begin
      key_in = key_ff;
      id_in  = id_ff;
      if (ctrl.drain) begin
         key_in = next_key;
         id_in  = next_id;
      end else if (ctrl.insert && (!occupied || greater)) begin
         if (prev_greater) begin
            key_in = prev_key;
            id_in  = prev_id;
         end else begin
            key_in = new_key;
            id_in  = new_id;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      id_ff  <= id_in;
   end

   assign key = key_ff;
   assign id  = id_ff;

endmodule

/* design/depth_insertion_sorter.sv */
// top level of the stable depth insertion sorter
//
// usage
//   req channel: one beat per item, tdata = {depth_key, item_id}, tlast marks
//   the final item of a set. items are kept in ascending signed key order,
//   equal keys in arrival order, in a chain of compare-and-shift cells.
//   rsp channel: after a tlast beat the whole set leaves in sorted order,
//   one beat per stored item; rsp_tlast marks the final beat and rsp_tuser
//   reports that items were dropped because the chain was full.
// loading and draining
//   loading takes one item per cycle while req_tready is high; every cell compares against the
//   broadcast key in parallel and shifts in the same edge.
//   the first result is valid in the cycle after the tlast beat; the run of n
//   results drains with one cell shift per beat and holds while rsp_tready is low.
//   req_tready is low while a run drains, so the next set waits for it to end.
// reset
//   synchronous and active high: the chain becomes empty, the overflow flag
//   clears and the block waits for items. cell contents are not cleared.
// stalls
//   while rsp_tready is low the current result holds in cell zero and the
//   chain does not move.
module depth_insertion_sorter #(
   parameter int MAX_ITEMS = dis_pkg::MAX_ITEMS_DEFAULT,
   parameter int KEY_BITS  = dis_pkg::KEY_BITS_DEFAULT,
   parameter int ID_BITS   = dis_pkg::ID_BITS_DEFAULT,
   localparam int DATA_W   = ((KEY_BITS + ID_BITS + 7) / 8) * 8
) (
   input  logic              clock,
   input  logic              reset,
   // item beats
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [DATA_W-1:0] req_tdata,   // item_id, depth_key, zero pad
   input  logic              req_tlast,   // set_end
   // sorted result beats
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [DATA_W-1:0] rsp_tdata,   // sorted_id, sorted_key, zero pad
   output logic              rsp_tlast,   // run_last
   output logic              rsp_tuser    // overflowed
);

   localparam int CNT_W = $clog2(MAX_ITEMS + 1);
   localparam int PAD_W = DATA_W - KEY_BITS - ID_BITS;

   dis_pkg::dis_state_type state_ff, state_in;
   logic [CNT_W-1:0]       fill_ff, fill_in;
   logic                   ovf_ff, ovf_in;
   dis_pkg::dis_ctrl_type  ctrl;

   logic                   req_beat, rsp_beat, full;
   logic [KEY_BITS-1:0]    new_key;
   logic [ID_BITS-1:0]     new_id;

   // greater flags handed up the chain, one extra slot below cell zero
   logic [MAX_ITEMS:0]     greater_w;
   logic [MAX_ITEMS-1:0]   occupied;

   assign new_id   = req_tdata[ID_BITS-1:0];
   assign new_key  = req_tdata[ID_BITS +: KEY_BITS];
   assign req_beat = req_tvalid && req_tready;
   assign rsp_beat = rsp_tvalid && rsp_tready;
   assign full     = (fill_ff == CNT_W'(MAX_ITEMS));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dis_pkg::ST_LOAD: begin
            if (req_beat && req_tlast) begin
               state_in = dis_pkg::ST_DRAIN;
            end
         end
         dis_pkg::ST_DRAIN: begin
            if (rsp_beat && (fill_ff == CNT_W'(1))) begin
               state_in = dis_pkg::ST_LOAD;
            end
         end
         default: state_in = dis_pkg::ST_LOAD;
      endcase
   end

   // handshake outputs and chain command
   always_comb begin
      req_tready  = 1'b0;
      rsp_tvalid  = 1'b0;
      ctrl.insert = 1'b0;
      ctrl.drain  = 1'b0;
      unique case (state_ff)
         dis_pkg::ST_LOAD: begin
            req_tready  = 1'b1;
            ctrl.insert = req_tvalid && !full;
         end
         dis_pkg::ST_DRAIN: begin
            rsp_tvalid = (fill_ff != '0);
            ctrl.drain = rsp_tready && (fill_ff != '0);
         end
         default: ;
      endcase
   end

   // fill count and overflow flag
   always_comb begin
      fill_in = fill_ff;
      ovf_in  = ovf_ff;
      if (ctrl.insert) begin
         fill_in = fill_ff + CNT_W'(1);
      end
      if (req_beat && full) begin
         ovf_in = 1'b1;   // store full, item dropped
      end
      if (ctrl.drain) begin
         fill_in = fill_ff - CNT_W'(1);
         if (fill_ff == CNT_W'(1)) begin
            ovf_in = 1'b0;   // run done, fresh set follows
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dis_pkg::ST_LOAD;
         fill_ff  <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         ovf_ff   <= ovf_in;
      end
   end

   // nothing is greater below cell zero
   assign greater_w[0] = 1'b0;

   logic [KEY_BITS-1:0] cell_key [MAX_ITEMS];
   logic [ID_BITS-1:0]  cell_id  [MAX_ITEMS];

   for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
      logic [KEY_BITS-1:0] below_key, above_key;
      logic [ID_BITS-1:0]  below_id, above_id;

      assign occupied[i] = (fill_ff > CNT_W'(i));

      // chain ends see empty neighbors
      if (i == 0) begin : g_bottom
         assign below_key = '0;
         assign below_id  = '0;
      end else begin : g_lower
         assign below_key = cell_key[i-1];
         assign below_id  = cell_id[i-1];
      end
      if (i == MAX_ITEMS - 1) begin : g_top
         assign above_key = '0;
         assign above_id  = '0;
      end else begin : g_upper
         assign above_key = cell_key[i+1];
         assign above_id  = cell_id[i+1];
      end

      dis_cell #(
         .KEY_BITS(KEY_BITS),
         .ID_BITS (ID_BITS)
      ) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .occupied    (occupied[i]),
         .new_key     (new_key),
         .new_id      (new_id),
         .prev_greater(greater_w[i]),
         .prev_key    (below_key),
         .prev_id     (below_id),
         .next_key    (above_key),
         .next_id     (above_id),
         .greater     (greater_w[i+1]),
         .key         (cell_key[i]),
         .id          (cell_id[i])
      );
   end

   // cell zero always holds the smallest remaining key
   if (PAD_W > 0) begin : g_pad
      assign rsp_tdata = {{PAD_W{1'b0}}, cell_key[0], cell_id[0]};
   end else begin : g_nopad
      assign rsp_tdata = {cell_key[0], cell_id[0]};
   end
   assign rsp_tlast = (fill_ff == CNT_W'(1));
   assign rsp_tuser = ovf_ff;

endmodule

/* design/dis_checker.sv */
// port-level checks for the depth insertion sorter and their bind
module dis_checker #(
   parameter int KEY_BITS = dis_pkg::KEY_BITS_DEFAULT,
   parameter int ID_BITS  = dis_pkg::ID_BITS_DEFAULT,
   localparam int DATA_W  = ((KEY_BITS + ID_BITS + 7) / 8) * 8
) (
   input logic              clock,
   input logic              reset,
   input logic              req_tvalid,
   input logic              req_tready,
   input logic              req_tlast,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [DATA_W-1:0] rsp_tdata,
   input logic              rsp_tlast
);

   // no item is taken while a run drains
   a_no_load_in_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("item channel ready during drain");

   // a set end starts the run in the next cycle
   a_run_starts: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> rsp_tvalid)
      else $error("run did not start after set end");

   // a run has no gaps until its final beat
   a_run_gapless: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> rsp_tvalid)
      else $error("gap inside sorted run");

   // after the final beat the block loads again
   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> (!rsp_tvalid && req_tready))
      else $error("block did not return to loading");

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

endmodule

bind depth_insertion_sorter dis_checker #(
   .KEY_BITS(KEY_BITS),
   .ID_BITS (ID_BITS)
) u_dis_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .req_tlast (req_tlast),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tlast (rsp_tlast)
);
